@@ sv/cpc_pkg.sv @@
// Shared types, constants and arctangent table for the polar/cartesian converter.
package cpc_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int ITERATIONS_DEF = 16;
	localparam int IN_W           = 16;
	localparam int OUT_W          = 17;

	localparam logic MODE_R2P = 1'b0;
	localparam logic MODE_P2R = 1'b1;

	localparam logic [15:0] GAIN_HI   = 16'h9B74;
	localparam logic [15:0] GAIN_LO   = 16'hEDA8;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] PH_RND    = 32'h0000_8000;

	localparam logic [OUT_W-1:0] PH_NEG_HALF = 17'h18000;
	localparam logic [OUT_W-1:0] PH_POS_QTR  = 17'h04000;
	localparam logic [OUT_W-1:0] PH_NEG_QTR  = 17'h1C000;

	typedef struct packed {
		logic             mode;
		logic             cordic;
		logic [OUT_W-1:0] byp0;
		logic [OUT_W-1:0] byp1;
	} ctl_t;

	// atan(2^-i), 2^32 units per turn
	function automatic logic [31:0] cpc_atan(input int idx);
		logic [31:0] a;
		case (idx)
			0:  a = 32'h20000000;
			1:  a = 32'h12E4051E;
			2:  a = 32'h09FB385B;
			3:  a = 32'h051111D4;
			4:  a = 32'h028B0D43;
			5:  a = 32'h0145D7E1;
			6:  a = 32'h00A2F61E;
			7:  a = 32'h00517C55;
			8:  a = 32'h0028BE53;
			9:  a = 32'h00145F2F;
			10: a = 32'h000A2F98;
			11: a = 32'h000517CC;
			12: a = 32'h00028BE6;
			13: a = 32'h000145F3;
			14: a = 32'h0000A2FA;
			15: a = 32'h0000517D;
			16: a = 32'h000028BE;
			17: a = 32'h0000145F;
			18: a = 32'h00000A30;
			19: a = 32'h00000518;
			20: a = 32'h0000028C;
			21: a = 32'h00000146;
			22: a = 32'h000000A3;
			23: a = 32'h00000051;
			24: a = 32'h00000029;
			25: a = 32'h00000014;
			26: a = 32'h0000000A;
			27: a = 32'h00000005;
			28: a = 32'h00000003;
			29: a = 32'h00000001;
			30: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage

@@ sv/cpc_prep.sv @@
// Input decode: quadrant fold, guard-bit scaling and absent-component results.
module cpc_prep import cpc_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int W          = DATA_WIDTH + 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_i,
	input  logic                mode,
	input  logic signed [15:0]  first_in,
	input  logic signed [15:0]  second_in,
	input  logic                first_present,
	input  logic                second_present,
	output logic                valid_o,
	output ctl_t                ctl_o,
	output logic signed [W-1:0] x_o,
	output logic signed [W-1:0] y_o,
	output logic [31:0]         z_o
);

	localparam int G = DATA_WIDTH - 8;

	logic signed [W-1:0] a_w, b_w, x_d, y_d;
	logic [31:0]         z_d;
	ctl_t                ctl_d;
	logic                valid_s1;
	ctl_t                ctl_s1;
	logic signed [W-1:0] x_s1, y_s1;
	logic [31:0]         z_s1;

	assign a_w = W'(first_in) <<< G;
	assign b_w = W'(second_in) <<< G;

	always_comb begin
		x_d = a_w;
		y_d = b_w;
		z_d = '0;
		if (mode == MODE_R2P) begin
			if (first_in[15]) begin
				x_d = -a_w;
				y_d = -b_w;
				z_d = HALF_TURN;
			end
		end else begin
			y_d = '0;
			z_d = {second_in, 16'h0000};
			// beyond +-90 degrees: turn by half a turn first
			if (second_in[15] ^ second_in[14]) begin
				x_d = -a_w;
				z_d = {~second_in[15], second_in[14:0], 16'h0000};
			end
		end
	end

	always_comb begin
		ctl_d.mode   = mode;
		ctl_d.cordic = first_present & second_present;
		ctl_d.byp0   = '0;
		ctl_d.byp1   = '0;
		if (mode == MODE_R2P) begin
			if (first_present && !second_present) begin
				ctl_d.byp0 = OUT_W'(first_in);
				ctl_d.byp1 = first_in[15] ? PH_NEG_HALF : '0;
			end else if (!first_present && second_present) begin
				ctl_d.byp0 = OUT_W'(second_in);
				if (second_in[15]) begin
					ctl_d.byp1 = PH_NEG_QTR;
				end else if (|second_in) begin
					ctl_d.byp1 = PH_POS_QTR;
				end
			end
		end else begin
			if (first_present && !second_present) begin
				ctl_d.byp0 = OUT_W'(first_in);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_d;
			x_s1   <= x_d;
			y_s1   <= y_d;
			z_s1   <= z_d;
		end
	end

	assign valid_o = valid_s1;
	assign ctl_o   = ctl_s1;
	assign x_o     = x_s1;
	assign y_o     = y_s1;
	assign z_o     = z_s1;

endmodule

@@ sv/cpc_cell.sv @@
// One CORDIC micro-rotation cell: vectoring or rotation by the beat's mode.
module cpc_cell import cpc_pkg::*; #(
	parameter int W     = DATA_WIDTH_DEF + 11,
	parameter int STAGE = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_i,
	input  ctl_t                ctl_i,
	input  logic signed [W-1:0] x_i,
	input  logic signed [W-1:0] y_i,
	input  logic [31:0]         z_i,
	output logic                valid_o,
	output ctl_t                ctl_o,
	output logic signed [W-1:0] x_o,
	output logic signed [W-1:0] y_o,
	output logic [31:0]         z_o
);

	logic                ccw;
	logic signed [W-1:0] xs, ys;
	logic [31:0]         ang;
	logic                valid_s1;
	ctl_t                ctl_s1;
	logic signed [W-1:0] x_s1, y_s1;
	logic [31:0]         z_s1;

	// rotation drives z to zero, vectoring drives y to zero
	assign ccw = (ctl_i.mode == MODE_P2R) ? ~z_i[31] : y_i[W-1];
	assign xs  = x_i >>> STAGE;
	assign ys  = y_i >>> STAGE;
	assign ang = cpc_atan(STAGE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_i;
			if (ccw) begin
				x_s1 <= x_i - ys;
				y_s1 <= y_i + xs;
				z_s1 <= z_i - ang;
			end else begin
				x_s1 <= x_i + ys;
				y_s1 <= y_i - xs;
				z_s1 <= z_i + ang;
			end
		end
	end

	assign valid_o = valid_s1;
	assign ctl_o   = ctl_s1;
	assign x_o     = x_s1;
	assign y_o     = y_s1;
	assign z_o     = z_s1;

endmodule

@@ sv/cpc_gain.sv @@
// Gain correction, rounding, saturation and final result select.
module cpc_gain import cpc_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int W          = DATA_WIDTH + 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_i,
	input  ctl_t                ctl_i,
	input  logic signed [W-1:0] x_i,
	input  logic signed [W-1:0] y_i,
	input  logic [31:0]         z_i,
	output logic                valid_o,
	output logic [OUT_W-1:0]    first_o,
	output logic [OUT_W-1:0]    second_o
);

	localparam int G  = DATA_WIDTH - 8;
	localparam int PW = W + 17;
	localparam int TW = PW + 1;
	localparam logic signed [TW-1:0] RND    = TW'(1) <<< (15 + G);
	localparam logic signed [TW-1:0] SAT_HI = TW'(65535);
	localparam logic signed [TW-1:0] SAT_LO = TW'(-65536);

	function automatic logic [OUT_W-1:0] sat(input logic signed [TW-1:0] v);
		logic [OUT_W-1:0] r;
		if (v > SAT_HI) begin
			r = 17'h0FFFF;
		end else if (v < SAT_LO) begin
			r = 17'h10000;
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

	logic signed [PW-1:0] xe, ye, k_hi, k_lo;
	logic [31:0]          z_rnd;
	logic                 valid_s1, valid_s2;
	ctl_t                 ctl_s1;
	logic signed [PW-1:0] xhi_s1, xlo_s1, yhi_s1, ylo_s1;
	logic [15:0]          ph_s1;
	logic signed [TW-1:0] tx, ty, rx, ry;
	logic [OUT_W-1:0]     first_s2, second_s2;

	assign xe    = PW'(x_i);
	assign ye    = PW'(y_i);
	assign k_hi  = PW'(GAIN_HI);
	assign k_lo  = PW'(GAIN_LO);
	assign z_rnd = z_i + PH_RND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_i;
			xhi_s1 <= xe * k_hi;
			xlo_s1 <= xe * k_lo;
			yhi_s1 <= ye * k_hi;
			ylo_s1 <= ye * k_lo;
			ph_s1  <= z_rnd[31:16];
		end
	end

	assign tx = TW'(xhi_s1) + TW'(xlo_s1 >>> 16) + RND;
	assign ty = TW'(yhi_s1) + TW'(ylo_s1 >>> 16) + RND;
	assign rx = tx >>> (16 + G);
	assign ry = ty >>> (16 + G);

	always_ff @(posedge clk) begin
		if (en) begin
			if (!ctl_s1.cordic) begin
				first_s2  <= ctl_s1.byp0;
				second_s2 <= ctl_s1.byp1;
			end else if (ctl_s1.mode == MODE_R2P) begin
				first_s2  <= sat(rx);
				second_s2 <= {ph_s1[15], ph_s1};
			end else begin
				first_s2  <= sat(rx);
				second_s2 <= sat(ry);
			end
		end
	end

	assign valid_o  = valid_s2;
	assign first_o  = first_s2;
	assign second_o = second_s2;

endmodule

@@ sv/complex_polar_cartesian_converter.sv @@
// Top level: streaming rectangular/polar converter built on a chain of CORDIC cells.
//
// Input beats arrive on s_axis: tdata carries first_in and second_in, tuser carries
// mode and the two presence flags. Mode 0 gives magnitude and phase, mode 1 gives
// real and imaginary parts; phase is a 16-bit binary angle (-32768 = -180 deg).
// Result beats leave on m_axis with first_out and second_out in tdata.
// One beat is taken per clock while s_axis_tready is high. A result reaches
// m_axis after passing one decode stage, one cell per iteration, two
// gain-correction stages, then the output register.
// The whole chain moves in lock step. When the receiver stalls, the output
// register holds its beat and a skid register takes the next finished one; the
// chain keeps accepting until the skid fills, then s_axis_tready drops until the
// output register takes the skid beat.
// Reset clears every valid flag; no beat is lost or repeated across a stall.
// DATA_WIDTH sets the guard bits (DATA_WIDTH - 8), ITERATIONS the cell count.
module complex_polar_cartesian_converter import cpc_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int ITERATIONS = ITERATIONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // first_in, second_in
	input  logic [2:0]  s_axis_tuser,   // mode, first_present, second_present
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // first_out, second_out, zero pad
);

	localparam int W  = DATA_WIDTH + 11;
	localparam int DW = 2 * OUT_W;

	logic                en;
	logic                vld_c [0:ITERATIONS];
	ctl_t                ctl_c [0:ITERATIONS];
	logic signed [W-1:0] x_c   [0:ITERATIONS];
	logic signed [W-1:0] y_c   [0:ITERATIONS];
	logic [31:0]         z_c   [0:ITERATIONS];
	logic                g_vld;
	logic [OUT_W-1:0]    g_first, g_second;
	logic [DW-1:0]       g_data;
	logic                out_vld_q, skid_vld_q;
	logic [DW-1:0]       out_data_q, skid_data_q;

	assign en            = ~skid_vld_q;
	assign s_axis_tready = en;

	cpc_prep #(
		.DATA_WIDTH (DATA_WIDTH),
		.W          (W)
	) u_prep (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.valid_i        (s_axis_tvalid),
		.mode           (s_axis_tuser[0]),
		.first_in       ($signed(s_axis_tdata[15:0])),
		.second_in      ($signed(s_axis_tdata[31:16])),
		.first_present  (s_axis_tuser[1]),
		.second_present (s_axis_tuser[2]),
		.valid_o        (vld_c[0]),
		.ctl_o          (ctl_c[0]),
		.x_o            (x_c[0]),
		.y_o            (y_c[0]),
		.z_o            (z_c[0])
	);

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
		cpc_cell #(
			.W     (W),
			.STAGE (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (vld_c[i]),
			.ctl_i   (ctl_c[i]),
			.x_i     (x_c[i]),
			.y_i     (y_c[i]),
			.z_i     (z_c[i]),
			.valid_o (vld_c[i+1]),
			.ctl_o   (ctl_c[i+1]),
			.x_o     (x_c[i+1]),
			.y_o     (y_c[i+1]),
			.z_o     (z_c[i+1])
		);
	end

	cpc_gain #(
		.DATA_WIDTH (DATA_WIDTH),
		.W          (W)
	) u_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_i  (vld_c[ITERATIONS]),
		.ctl_i    (ctl_c[ITERATIONS]),
		.x_i      (x_c[ITERATIONS]),
		.y_i      (y_c[ITERATIONS]),
		.z_i      (z_c[ITERATIONS]),
		.valid_o  (g_vld),
		.first_o  (g_first),
		.second_o (g_second)
	);

	assign g_data = {g_second, g_first};

	// output register with one-beat skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (m_axis_tready || !out_vld_q) begin
			out_vld_q  <= skid_vld_q | g_vld;
			skid_vld_q <= 1'b0;
		end else if (g_vld && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_axis_tready || !out_vld_q) begin
			out_data_q <= skid_vld_q ? skid_data_q : g_data;
		end else if (g_vld && en) begin
			skid_data_q <= g_data;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(40 - DW){1'b0}}, out_data_q};

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a beat while output register is empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready && g_vld))
		else $error("skid filled without a stalled output");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && out_vld_q && !m_axis_tready) |=> (skid_vld_q && $stable(skid_data_q)))
		else $error("skid beat lost during stall");

endmodule
